>>> src/wheel_speed_from_period_core_assert.svh
// ----------------------------------------------------------------------------
// Wheel speed core assertion macros
// Shared property forms for the wheel speed core checker.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_FROM_PERIOD_CORE_ASSERT_SVH
`define WHEEL_SPEED_FROM_PERIOD_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define WSFP_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wsfp checker: implication failed");

// Next-cycle implication, ignored while reset is high.
`define WSFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wsfp checker: next-cycle implication failed");

// Next-cycle implication that is also checked across reset.
`define WSFP_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("wsfp checker: reset implication failed");

`endif

>>> src/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// Wheel speed core package
// Constants, register indexes and pipeline stage types of the wheel speed core.
// ----------------------------------------------------------------------------
package wsfp_pkg;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam int SPEED_K_W = 20;
   localparam logic [SPEED_K_W-1:0] SPEED_K = 20'd804248;

   localparam int DIAM_W  = 8;
   localparam int SPEED_W = 16;
   localparam int PER_W   = 32;
   localparam int NUMER_W = SPEED_K_W + DIAM_W;

   localparam int QUO_W = 16;
   localparam int PIPE_DEPTH = 2 * (QUO_W + 1) + 3;

   localparam logic [DIAM_W-1:0]  DIAM_RESET    = 8'd100;
   localparam logic [NUMER_W-1:0] NUMER_RESET   = NUMER_W'(804248 * 100);
   localparam logic [SPEED_W-1:0] MIN_RESET     = 16'd0;
   localparam logic [SPEED_W-1:0] MAX_RESET     = 16'hFFFF;
   localparam logic [SPEED_W-1:0] ULOW_RESET    = 16'd0;
   localparam logic [SPEED_W-1:0] UHIGH_RESET   = 16'hFFFF;

   typedef enum logic [2:0] {
      REG_WHEEL_DIAMETER = 3'd0,
      REG_MIN_SPEED      = 3'd1,
      REG_MAX_SPEED      = 3'd2,
      REG_UNIFIED_LOW    = 3'd3,
      REG_UNIFIED_HIGH   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [PER_W-1:0] period;
      logic [PER_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             zero;
   } div1_type;

   typedef struct packed {
      logic [SPEED_W-1:0] s;
      logic [QUO_W-1:0]   alo;
      logic [SPEED_W-1:0] rem;
      logic [QUO_W-1:0]   quo;
      logic               neg;
   } div2_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_value;
      logic [SPEED_W-1:0] speed_scaled;
   } result_type;

endpackage

>>> src/wheel_speed_from_period_core.sv
// ----------------------------------------------------------------------------
// Wheel speed from pulse period
// Turns a wheel pulse period into a clamped speed and a rescaled speed.
// ----------------------------------------------------------------------------
// The core takes one item per clock while the skid register is empty, and
// returns one result item for each, in order. The pipeline holds two
// restoring dividers, each unrolled into sixteen pipeline stages that resolve
// one quotient bit apiece: one forms the speed from the period and one maps
// the speed onto the unified range. A skid register at the output takes the
// result that is refused, so a stalled result never blocks the item behind
// it for more than the stall itself. The user must write registers through
// the APB port only while no item is in flight; the core does not enforce it.
module wheel_speed_from_period_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [31:0]                       req_period_between_us,
   input  logic [31:0]                       req_since_capture_us,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_speed_value,
   output logic [15:0]                       rsp_speed_scaled,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wsfp_pkg::ADDR_W-1:0]       paddr,
   input  logic [wsfp_pkg::DATA_W-1:0]       pwdata,
   output logic [wsfp_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import wsfp_pkg::*;

   logic [DIAM_W-1:0]  diam_ff;
   logic [NUMER_W-1:0] numer_ff;
   logic [SPEED_W-1:0] min_ff;
   logic [SPEED_W-1:0] max_ff;
   logic [SPEED_W-1:0] ulow_ff;
   logic [SPEED_W-1:0] uhigh_ff;
   logic               cfg_wr;
   reg_index_type      reg_sel;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic                  advance;
   logic [PER_W-1:0]      period_ff;
   logic [PER_W-1:0]      period_in;
   div1_type              div1_ff [0:QUO_W];
   div1_type              div1_in [0:QUO_W];
   logic [SPEED_W-1:0]    clamp_s_ff;
   logic [SPEED_W-1:0]    clamp_t_ff;
   logic [SPEED_W-1:0]    clamp_s_in;
   logic [SPEED_W-1:0]    clamp_t_in;
   div2_type              div2_ff [0:QUO_W];
   div2_type              div2_in [0:QUO_W];
   result_type            out_ff;
   result_type            out_in;
   result_type            skid_ff;
   logic                  skid_valid_ff;
   logic [SPEED_W-1:0]    den;

   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite & pready;
   assign reg_sel = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         diam_ff  <= DIAM_RESET;
         numer_ff <= NUMER_RESET;
         min_ff   <= MIN_RESET;
         max_ff   <= MAX_RESET;
         ulow_ff  <= ULOW_RESET;
         uhigh_ff <= UHIGH_RESET;
      end else if (cfg_wr) begin
         unique case (reg_sel)
            REG_WHEEL_DIAMETER: begin
               diam_ff  <= pwdata[DIAM_W-1:0];
               numer_ff <= {{DIAM_W{1'b0}}, SPEED_K} *
                           {{SPEED_K_W{1'b0}}, pwdata[DIAM_W-1:0]};
            end
            REG_MIN_SPEED:      min_ff   <= pwdata[SPEED_W-1:0];
            REG_MAX_SPEED:      max_ff   <= pwdata[SPEED_W-1:0];
            REG_UNIFIED_LOW:    ulow_ff  <= pwdata[SPEED_W-1:0];
            REG_UNIFIED_HIGH:   uhigh_ff <= pwdata[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WHEEL_DIAMETER: prdata = {{(DATA_W-DIAM_W){1'b0}}, diam_ff};
         REG_MIN_SPEED:      prdata = {{(DATA_W-SPEED_W){1'b0}}, min_ff};
         REG_MAX_SPEED:      prdata = {{(DATA_W-SPEED_W){1'b0}}, max_ff};
         REG_UNIFIED_LOW:    prdata = {{(DATA_W-SPEED_W){1'b0}}, ulow_ff};
         REG_UNIFIED_HIGH:   prdata = {{(DATA_W-SPEED_W){1'b0}}, uhigh_ff};
         default:            prdata = '0;
      endcase
   end

   // The whole pipeline moves together and holds only while the skid is full.
   assign advance   = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign den       = max_ff - min_ff;

   assign period_in = (req_since_capture_us > req_period_between_us) ?
                      req_since_capture_us : req_period_between_us;

   always_comb begin
      div1_in[0].period = period_ff;
      div1_in[0].rem    = {{(PER_W+QUO_W-NUMER_W){1'b0}}, numer_ff[NUMER_W-1:QUO_W]};
      div1_in[0].quo    = '0;
      div1_in[0].ovf    = {{(PER_W+QUO_W-NUMER_W){1'b0}}, numer_ff[NUMER_W-1:QUO_W]}
                          >= period_ff;
      div1_in[0].zero   = (period_ff == '0);
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_div1
      logic [PER_W:0] rem_sh;
      logic           ge;
      always_comb begin
         rem_sh     = {div1_ff[k-1].rem, numer_ff[QUO_W-k]};
         ge         = rem_sh >= {1'b0, div1_ff[k-1].period};
         div1_in[k] = div1_ff[k-1];
         div1_in[k].rem = ge ? PER_W'(rem_sh - {1'b0, div1_ff[k-1].period})
                             : rem_sh[PER_W-1:0];
         div1_in[k].quo = {div1_ff[k-1].quo[QUO_W-2:0], ge};
      end
   end

   always_comb begin
      logic [SPEED_W-1:0] raw;
      logic [SPEED_W-1:0] upper;
      raw = div1_ff[QUO_W].zero ? '0 :
            div1_ff[QUO_W].ovf  ? '1 : div1_ff[QUO_W].quo;
      upper      = (raw > max_ff) ? max_ff : raw;
      clamp_s_in = (upper < min_ff) ? min_ff : upper;
      clamp_t_in = clamp_s_in - min_ff;
   end

   always_comb begin
      logic                 neg;
      logic [SPEED_W-1:0]   mag;
      logic [2*SPEED_W-1:0] prod;
      neg  = uhigh_ff < ulow_ff;
      mag  = neg ? (ulow_ff - uhigh_ff) : (uhigh_ff - ulow_ff);
      prod = {{SPEED_W{1'b0}}, clamp_t_ff} * {{SPEED_W{1'b0}}, mag};
      div2_in[0].s   = clamp_s_ff;
      div2_in[0].rem = prod[2*SPEED_W-1:SPEED_W];
      div2_in[0].alo = prod[SPEED_W-1:0];
      div2_in[0].quo = '0;
      div2_in[0].neg = neg;
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_div2
      logic [SPEED_W:0] rem_sh;
      logic             ge;
      always_comb begin
         rem_sh     = {div2_ff[k-1].rem, div2_ff[k-1].alo[QUO_W-k]};
         ge         = rem_sh >= {1'b0, den};
         div2_in[k] = div2_ff[k-1];
         div2_in[k].rem = ge ? SPEED_W'(rem_sh - {1'b0, den}) : rem_sh[SPEED_W-1:0];
         div2_in[k].quo = {div2_ff[k-1].quo[QUO_W-2:0], ge};
      end
   end

   always_comb begin
      logic [SPEED_W+1:0] sum;
      logic [SPEED_W-1:0] sat;
      if (div2_ff[QUO_W].neg) begin
         sum = {2'b00, ulow_ff} - ({2'b00, div2_ff[QUO_W].quo} +
                                   {{(SPEED_W+1){1'b0}}, |div2_ff[QUO_W].rem});
      end else begin
         sum = {2'b00, ulow_ff} + {2'b00, div2_ff[QUO_W].quo};
      end
      sat = sum[SPEED_W+1] ? '0 : (sum[SPEED_W] ? '1 : sum[SPEED_W-1:0]);
      out_in.speed_value  = div2_ff[QUO_W].s;
      out_in.speed_scaled = (max_ff > min_ff) ? sat : ulow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff      <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
            skid_valid_ff <= valid_ff[PIPE_DEPTH-1] & rsp_stall;
         end else if (~rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         period_ff  <= period_in;
         div1_ff    <= div1_in;
         clamp_s_ff <= clamp_s_in;
         clamp_t_ff <= clamp_t_in;
         div2_ff    <= div2_in;
         out_ff     <= out_in;
         skid_ff    <= out_ff;
      end
   end

   assign rsp_valid        = skid_valid_ff | valid_ff[PIPE_DEPTH-1];
   assign rsp_speed_value  = skid_valid_ff ? skid_ff.speed_value  : out_ff.speed_value;
   assign rsp_speed_scaled = skid_valid_ff ? skid_ff.speed_scaled : out_ff.speed_scaled;

endmodule

>>> src/wsfp_checker.sv
// ----------------------------------------------------------------------------
// Wheel speed core checker
// Port-level checks of item flow through the wheel speed core.
// ----------------------------------------------------------------------------
`include "wheel_speed_from_period_core_assert.svh"

module wsfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [15:0]                       rsp_speed_value,
   input logic [15:0]                       rsp_speed_scaled
);
   import wsfp_pkg::*;

   localparam int CAPACITY = PIPE_DEPTH + 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] in_flight_ff;
   logic [CNT_W-1:0] in_flight_in;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid & ~req_stall;
   assign rsp_take = rsp_valid & ~rsp_stall;

   always_comb begin
      in_flight_in = in_flight_ff + {{(CNT_W-1){1'b0}}, req_take}
                                  - {{(CNT_W-1){1'b0}}, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // A result may only appear for an item that was accepted and not yet delivered.
   `WSFP_ASSERT_IMPLIES(a_no_invented_result, rsp_valid, in_flight_ff != '0)

   // With the pipeline and the skid register both full, no item may enter.
   `WSFP_ASSERT_IMPLIES(a_full_core_stalls, in_flight_ff == CNT_W'(CAPACITY), req_stall)

   `WSFP_ASSERT_NEXT(a_result_holds, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_speed_value) && $stable(rsp_speed_scaled))

   `WSFP_ASSERT_NEXT_ALWAYS(a_reset_empties, reset, !rsp_valid && !req_stall)

endmodule

bind wheel_speed_from_period_core wsfp_checker u_wsfp_checker (.*);

>>> verif/tb_wheel_speed_from_period_core.sv
// ----------------------------------------------------------------------------
// Wheel speed core testbench
// Drives period items into the wheel speed core under random idling on both
// sides, predicts the clamped and rescaled speed of every accepted item from
// a shadow copy of the registers, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_wheel_speed_from_period_core;
   timeunit 1ns;
   timeprecision 1ps;

   import wsfp_pkg::*;

   localparam int REG_COUNT     = 5;
   localparam int REG_SLOTS     = 8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 75;

   typedef struct {
      logic [DIAM_W-1:0]  diameter;
      logic [SPEED_W-1:0] min_speed;
      logic [SPEED_W-1:0] max_speed;
      logic [SPEED_W-1:0] unified_low;
      logic [SPEED_W-1:0] unified_high;
   } speed_cfg_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PER_W-1:0]    req_period_between_us = '0;
   logic [PER_W-1:0]    req_since_capture_us = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SPEED_W-1:0]  rsp_speed_value;
   logic [SPEED_W-1:0]  rsp_speed_scaled;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   speed_cfg_type       speed_cfg;
   result_type          pending_speeds[$];
   bit                  quiet = 1'b0;
   int unsigned         mismatch_count = 0;
   int unsigned         items_sent = 0;
   int unsigned         results_checked = 0;
   int unsigned         reg_writes = 0;
   int unsigned         cycle_count = 0;
   int unsigned         stall_left = 0;

   wheel_speed_from_period_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_period_between_us (req_period_between_us),
      .req_since_capture_us  (req_since_capture_us),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_speed_value       (rsp_speed_value),
      .rsp_speed_scaled      (rsp_speed_scaled),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_speeds.size());
         $display("FAIL wheel_speed_from_period_core");
         $finish;
      end
   end

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   function automatic result_type predict_speed(input logic [PER_W-1:0] between,
                                                input logic [PER_W-1:0] since);
      logic [PER_W-1:0] period;
      longint unsigned  raw;
      longint           s;
      longint           den;
      longint           num;
      longint           q;
      longint           r;
      result_type       res;
      period = (since > between) ? since : between;
      raw = 0;
      if (period != 0) begin
         raw = (64'(SPEED_K) * 64'(speed_cfg.diameter)) / 64'(period);
      end
      s = (raw > 64'(speed_cfg.max_speed)) ? longint'(speed_cfg.max_speed) : longint'(raw);
      if (s < longint'(speed_cfg.min_speed)) begin
         s = longint'(speed_cfg.min_speed);
      end
      res.speed_value = s[SPEED_W-1:0];
      den = longint'(speed_cfg.max_speed) - longint'(speed_cfg.min_speed);
      if (den <= 0) begin
         res.speed_scaled = speed_cfg.unified_low;
      end else begin
         num = (s - longint'(speed_cfg.min_speed)) *
               (longint'(speed_cfg.unified_high) - longint'(speed_cfg.unified_low));
         q = num / den;
         if (num < 0 && (num % den) != 0) begin
            q = q - 1;
         end
         r = longint'(speed_cfg.unified_low) + q;
         if (r < 0) begin
            r = 0;
         end
         if (r > 65535) begin
            r = 65535;
         end
         res.speed_scaled = r[SPEED_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [PER_W-1:0] rand_period();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return $urandom();
         2: return $urandom_range(1, 4096);
         3: return $urandom_range(4096, 1 << 20);
         4: return $urandom_range(1, 100000);
         5: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom_range(1000, 20000);
      endcase
   endfunction

   // Valid stays high after acceptance so that a back-to-back item needs no
   // second assignment in the same step; it drops on a gap or a drain.
   task automatic send_item(input logic [PER_W-1:0] between,
                            input logic [PER_W-1:0] since);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_period_between_us <= between;
      req_since_capture_us <= since;
      do @(posedge clock); while (req_stall);
      pending_speeds.push_back(predict_speed(between, since));
      items_sent++;
   endtask

   task automatic send_random_item();
      if ($urandom_range(0, 31) == 0) begin
         quiet = ~quiet;
      end
      send_item(rand_period(), rand_period());
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (pending_speeds.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      reg_writes++;
      case (idx)
         int'(REG_WHEEL_DIAMETER): speed_cfg.diameter = value[DIAM_W-1:0];
         int'(REG_MIN_SPEED):      speed_cfg.min_speed = value[SPEED_W-1:0];
         int'(REG_MAX_SPEED):      speed_cfg.max_speed = value[SPEED_W-1:0];
         int'(REG_UNIFIED_LOW):    speed_cfg.unified_low = value[SPEED_W-1:0];
         int'(REG_UNIFIED_HIGH):   speed_cfg.unified_high = value[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(input int idx, output logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_W'(idx * 4);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_speed_cfg(input logic [DIAM_W-1:0] diameter,
                                input logic [SPEED_W-1:0] min_speed,
                                input logic [SPEED_W-1:0] max_speed,
                                input logic [SPEED_W-1:0] unified_low,
                                input logic [SPEED_W-1:0] unified_high);
      wait_results_done();
      csr_write(int'(REG_WHEEL_DIAMETER), DATA_W'(diameter));
      csr_write(int'(REG_MIN_SPEED), DATA_W'(min_speed));
      csr_write(int'(REG_MAX_SPEED), DATA_W'(max_speed));
      csr_write(int'(REG_UNIFIED_LOW), DATA_W'(unified_low));
      csr_write(int'(REG_UNIFIED_HIGH), DATA_W'(unified_high));
   endtask

   task automatic check_regs();
      logic [DATA_W-1:0] got;
      logic [DATA_W-1:0] want;
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_read(i, got);
         case (i)
            int'(REG_WHEEL_DIAMETER): want = DATA_W'(speed_cfg.diameter);
            int'(REG_MIN_SPEED):      want = DATA_W'(speed_cfg.min_speed);
            int'(REG_MAX_SPEED):      want = DATA_W'(speed_cfg.max_speed);
            int'(REG_UNIFIED_LOW):    want = DATA_W'(speed_cfg.unified_low);
            default:                  want = DATA_W'(speed_cfg.unified_high);
         endcase
         if (got !== want) begin
            note_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h", i, got, want));
         end
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_speeds.size() == 0) begin
               note_mismatch($sformatf("result %0d/%0d with no item outstanding",
                                       rsp_speed_value, rsp_speed_scaled));
            end else begin
               want = pending_speeds.pop_front();
               results_checked++;
               if (rsp_speed_value !== want.speed_value) begin
                  note_mismatch($sformatf("speed_value %0d, expected %0d",
                                          rsp_speed_value, want.speed_value));
               end
               if (rsp_speed_scaled !== want.speed_scaled) begin
                  note_mismatch($sformatf("speed_scaled %0d, expected %0d",
                                          rsp_speed_scaled, want.speed_scaled));
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 10);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_reset_values();
      speed_cfg.diameter = DIAM_RESET;
      speed_cfg.min_speed = MIN_RESET;
      speed_cfg.max_speed = MAX_RESET;
      speed_cfg.unified_low = ULOW_RESET;
      speed_cfg.unified_high = UHIGH_RESET;
      check_regs();
   endtask

   task automatic test_directed_cases();
      send_item(32'd0, 32'd0);
      send_item(32'd1, 32'd0);
      send_item(32'd0, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'd5);
      send_item(32'd1227, 32'd1228);
      send_item(32'd12345, 32'd0);
      set_speed_cfg(8'd255, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'd3130, 32'd0);
      set_speed_cfg(8'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      send_item(32'd1000, 32'd1);
      set_speed_cfg(8'd100, 16'd1000, 16'd20000, 16'd500, 16'd60000);
      send_item(32'd0, 32'd0);
      send_item(32'd1, 32'd0);
      send_item(32'd8000, 32'd0);
      // Minimum above maximum and equal bounds both collapse the mapping.
      set_speed_cfg(8'd100, 16'd30000, 16'd100, 16'd1234, 16'd50000);
      send_item(32'd5000, 32'd0);
      send_item(32'd0, 32'd0);
      set_speed_cfg(8'd100, 16'd7777, 16'd7777, 16'd4321, 16'd9999);
      send_item(32'd4000, 32'd0);
      set_speed_cfg(8'd100, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_item(32'd2000, 32'd0);
      send_item(32'd0, 32'd0);
      send_item(32'd1, 32'd0);
      send_item(32'd20000, 32'd3);
      set_speed_cfg(DIAM_RESET, MIN_RESET, MAX_RESET, ULOW_RESET, UHIGH_RESET);
   endtask

   task automatic test_unknown_register();
      wait_results_done();
      for (int i = REG_COUNT; i < REG_SLOTS; i++) begin
         csr_write(i, $urandom());
      end
      check_regs();
   endtask

   task automatic test_full_rate();
      quiet = 1'b1;
      repeat (64) send_item(rand_period(), rand_period());
      wait_results_done();
      quiet = 1'b0;
   endtask

   task automatic test_sender_pause();
      for (int batch = 0; batch < 3; batch++) begin
         repeat (20) send_random_item();
         wait_results_done();
      end
   endtask

   task automatic test_random_settings();
      logic [DIAM_W-1:0]  diameter;
      logic [SPEED_W-1:0] lo;
      logic [SPEED_W-1:0] hi;
      logic [SPEED_W-1:0] ulo;
      logic [SPEED_W-1:0] uhi;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: diameter = 8'd0;
            1: diameter = 8'd255;
            default: diameter = DIAM_W'($urandom_range(0, 255));
         endcase
         lo = SPEED_W'($urandom());
         hi = SPEED_W'($urandom());
         case ($urandom_range(0, 4))
            0: begin
               lo = 16'd0;
               hi = 16'hFFFF;
            end
            1: begin
               if (lo > hi) begin
                  {lo, hi} = {hi, lo};
               end
            end
            2: begin
               if (lo < hi) begin
                  {lo, hi} = {hi, lo};
               end
            end
            3: hi = lo;
            default: begin
               lo = SPEED_W'($urandom_range(0, 2000));
               hi = SPEED_W'(lo + $urandom_range(0, 3000));
            end
         endcase
         ulo = SPEED_W'($urandom());
         uhi = SPEED_W'($urandom());
         case ($urandom_range(0, 3))
            0: begin
               ulo = 16'd0;
               uhi = 16'hFFFF;
            end
            1: begin
               ulo = 16'hFFFF;
               uhi = 16'd0;
            end
            default: ;
         endcase
         set_speed_cfg(diameter, lo, hi, ulo, uhi);
         repeat (PHASE_ITEMS) send_random_item();
      end
      wait_results_done();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_cases();
      test_unknown_register();
      test_full_rate();
      test_sender_pause();
      test_random_settings();
      wait_results_done();
      quiet = 1'b1;
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (pending_speeds.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", pending_speeds.size()));
      end
      $display("Checked %0d results from %0d items over %0d register writes,",
               results_checked, items_sent, reg_writes);
      $display("with random gaps and stalls on both channels; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS wheel_speed_from_period_core");
      end else begin
         $display("FAIL wheel_speed_from_period_core");
      end
      $finish;
   end

endmodule

>>> wheel_speed_from_period_core.f
+incdir+src
src/wsfp_pkg.sv
src/wheel_speed_from_period_core.sv
src/wsfp_checker.sv
verif/tb_wheel_speed_from_period_core.sv
